[src/lkc_pkg.sv]
`default_nettype none

package lkc_pkg;

    // Cache geometry.
    localparam int ENTRIES       = 16;
    localparam int TAG_BITS      = 64;
    localparam int VALUE_BITS    = 32;

    // Widths of the item fields.
    localparam int TAG_FIELD_W   = 64;
    localparam int VALUE_FIELD_W = 32;
    localparam int STATUS_W      = 3;
    localparam int CAP_W         = 5;

    // Derived widths.
    localparam int IDX_W         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W        = IDX_W;
    localparam int OCC_W         = $clog2(ENTRIES + 1);
    localparam int CMP_W         = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam int STORE_VALUE_W = (VALUE_BITS < VALUE_FIELD_W) ? VALUE_BITS : VALUE_FIELD_W;

    // Capacity after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Operation codes.
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EVICTED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd4;

    // Request item.
    typedef struct packed {
        logic                     op;
        logic [TAG_FIELD_W-1:0]   points_tag;
        logic [TAG_FIELD_W-1:0]   field_tag;
        logic [VALUE_FIELD_W-1:0] value_in;
    } lkc_req_t;

    // Response item.
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [VALUE_FIELD_W-1:0] value_out;
    } lkc_rsp_t;

    // Contents of one cache entry.
    typedef struct packed {
        logic [TAG_BITS-1:0]      points_tag;
        logic [TAG_BITS-1:0]      field_tag;
        logic [STORE_VALUE_W-1:0] value;
    } lkc_entry_t;

    // Write request into the entry store.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        lkc_entry_t       data;
    } lkc_wr_t;

endpackage

`default_nettype wire

[src/lkc_store.sv]
`default_nettype none

module lkc_store
    import lkc_pkg::*;
(
    input  wire logic             clk,
    input  wire lkc_wr_t          wr,
    input  wire logic [IDX_W-1:0] rd_addr,
    output lkc_entry_t            rd_data
);

    // Tag and value storage; the cache uses the contents only while the slot is valid.
    lkc_entry_t entry_mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            entry_mem[wr.addr] <= wr.data;
        end
    end

    // The scan reads one slot per cycle; the read data is registered, so the address is presented the cycle before.
    always_ff @(posedge clk)
    begin
        rd_data <= entry_mem[rd_addr];
    end

endmodule

`default_nettype wire

[src/lru_keyed_cache_top.sv]
// Sequence: the accepted item is compared against all ENTRIES slots in S_SCAN, then S_UPDATE
// registers the response; S_UPDATE waits while the previous response has not been taken.
// Items are handled one at a time, limited by the single tag comparator that visits
// one slot per cycle. The response register lets the next item enter while a result waits.
// Reset: asynchronous, active low; all slots invalid, occupancy zero, capacity 16.
`default_nettype none

module lru_keyed_cache_top
    import lkc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CAP_W-1:0] cfg_data,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire lkc_req_t         req,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output lkc_rsp_t              rsp
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic [IDX_W-1:0]         idx_reg;
    lkc_req_t                 item_reg;
    logic                     hit_found_reg;
    logic [IDX_W-1:0]         hit_idx_reg;
    logic [RANK_W-1:0]        hit_rank_reg;
    logic [STORE_VALUE_W-1:0] hit_value_reg;
    logic                     free_found_reg;
    logic [IDX_W-1:0]         free_idx_reg;
    logic [IDX_W-1:0]         oldest_idx_reg;
    logic [ENTRIES-1:0]       valid_reg, valid_next;
    logic [RANK_W-1:0]        rank_reg [ENTRIES];
    logic [RANK_W-1:0]        rank_next [ENTRIES];
    logic [OCC_W-1:0]         occ_reg, occ_next;
    logic [CAP_W-1:0]         capacity_reg;
    lkc_rsp_t                 rsp_reg, rsp_next;
    logic                     rsp_valid_reg;

    lkc_wr_t                  wr;
    lkc_entry_t               rd_data;
    logic [IDX_W-1:0]         scan_addr;
    logic                     slot_valid;
    logic                     slot_match;
    logic                     slot_oldest;
    logic                     out_free;
    logic [CMP_W-1:0]         cap_eff;
    logic                     evict;
    logic                     insert;
    logic [IDX_W-1:0]         ins_idx;

    lkc_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (scan_addr),
        .rd_data (rd_data)
    );

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    // Read address runs one slot ahead of the scan index, so the registered
    // store output lines up with idx_reg.
    always_comb
    begin
        scan_addr = idx_reg;
        if (state_reg == S_IDLE)
        begin
            scan_addr = '0;
        end
        else if ((state_reg == S_SCAN) && (idx_reg != IDX_W'(ENTRIES - 1)))
        begin
            scan_addr = IDX_W'(idx_reg + 1'b1);
        end
    end

    // Comparator for the slot under the scan index.
    assign slot_valid  = valid_reg[idx_reg];
    assign slot_match  = slot_valid
                         && (rd_data.points_tag == item_reg.points_tag[TAG_BITS-1:0])
                         && (rd_data.field_tag == item_reg.field_tag[TAG_BITS-1:0]);
    assign slot_oldest = slot_valid && (rank_reg[idx_reg] == RANK_W'(occ_reg - 1'b1));

    // Effective capacity, clipped to the number of slots.
    assign cap_eff = (CMP_W'(capacity_reg) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES)
                                                              : CMP_W'(capacity_reg);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (idx_reg == IDX_W'(ENTRIES - 1))
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Update of ranks, valid bits, occupancy and the response once the scan is done.
    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        occ_next   = occ_reg;
        rsp_next   = '{status: ST_MISS, value_out: '0};
        evict      = 1'b0;
        insert     = 1'b0;
        ins_idx    = free_idx_reg;
        if (item_reg.op == OP_LOOKUP)
        begin
            if (hit_found_reg)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (valid_reg[i] && (rank_reg[i] < hit_rank_reg))
                    begin
                        rank_next[i] = RANK_W'(rank_reg[i] + 1'b1);
                    end
                end
                rank_next[hit_idx_reg] = '0;
                rsp_next.status    = ST_HIT;
                rsp_next.value_out = VALUE_FIELD_W'(hit_value_reg);
            end
        end
        else if (hit_found_reg)
        begin
            rsp_next.status = ST_DUP;
        end
        else
        begin
            rsp_next.status = ST_INSERTED;
            insert = (cap_eff != '0);
            if (CMP_W'(occ_reg) >= cap_eff)
            begin
                rsp_next.status = ST_EVICTED;
                evict = (occ_reg != '0);
            end
            if (evict)
            begin
                valid_next[oldest_idx_reg] = 1'b0;
                if (!free_found_reg || (oldest_idx_reg < free_idx_reg))
                begin
                    ins_idx = oldest_idx_reg;
                end
            end
            if (insert)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (valid_next[i])
                    begin
                        rank_next[i] = RANK_W'(rank_reg[i] + 1'b1);
                    end
                end
                valid_next[ins_idx] = 1'b1;
                rank_next[ins_idx]  = '0;
            end
            occ_next = OCC_W'(occ_reg - OCC_W'(evict) + OCC_W'(insert));
        end
    end

    // Store write for a new entry.
    always_comb
    begin
        wr.en              = (state_reg == S_UPDATE) && out_free && insert;
        wr.addr            = ins_idx;
        wr.data.points_tag = item_reg.points_tag[TAG_BITS-1:0];
        wr.data.field_tag  = item_reg.field_tag[TAG_BITS-1:0];
        wr.data.value      = item_reg.value_in[STORE_VALUE_W-1:0];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            occ_reg       <= '0;
            capacity_reg  <= CAP_RESET;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
            if ((state_reg == S_UPDATE) && out_free)
            begin
                valid_reg     <= valid_next;
                rank_reg      <= rank_next;
                occ_reg       <= occ_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Item capture and scan bookkeeping.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && req_valid)
        begin
            item_reg       <= req;
            idx_reg        <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (state_reg == S_SCAN)
        begin
            if (slot_match && !hit_found_reg)
            begin
                hit_found_reg <= 1'b1;
                hit_idx_reg   <= idx_reg;
                hit_rank_reg  <= rank_reg[idx_reg];
                hit_value_reg <= rd_data.value;
            end
            if (!slot_valid && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= idx_reg;
            end
            if (slot_oldest)
            begin
                oldest_idx_reg <= idx_reg;
            end
            if (idx_reg != IDX_W'(ENTRIES - 1))
            begin
                idx_reg <= IDX_W'(idx_reg + 1'b1);
            end
        end
        if ((state_reg == S_UPDATE) && out_free)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

`default_nettype wire
